// ===== design/tsm_pkg.sv =====
// Shared types and constants for the topic subscription matcher.
package tsm_pkg;

	typedef enum logic [1:0] {
		KIND_CONNECT    = 2'd0,
		KIND_DISCONNECT = 2'd1,
		KIND_SUBSCRIBE  = 2'd2,
		KIND_PUBLISH    = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACK_WAIT,
		ST_PUB_CMP,
		ST_PUB_EVAL,
		ST_PUB_OUT
	} state_t;

	localparam logic RES_ACK = 1'b0;
	localparam logic RES_PUB = 1'b1;

	localparam logic [7:0] WILDCARD_BYTE = 8'h23;

	localparam int MASK_W    = 16;
	localparam int COUNT_W   = 5;
	localparam int COUNT_MAX = 31;

	typedef struct packed {
		logic connect;
		logic disconnect;
		logic sub_byte;
		logic sub_last;
		logic pub_read;
		logic pub_cmp;
		logic pub_eval;
		logic load_ack;
		logic load_pub;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

endpackage

// ===== design/tsm_ctrl.sv =====
// Controller state machine of the topic subscription matcher.
module tsm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       kind,
	input  logic             last,
	input  tsm_pkg::status_t status,
	output tsm_pkg::cmd_t    cmd
);

	tsm_pkg::state_t state_q, state_d;
	logic            last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tsm_pkg::ST_IDLE;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.pub_read) begin
				last_q <= last;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		cmd      = '0;
		case (state_q)
			tsm_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					case (tsm_pkg::kind_t'(kind))
						tsm_pkg::KIND_CONNECT:    cmd.connect = 1'b1;
						tsm_pkg::KIND_DISCONNECT: cmd.disconnect = 1'b1;
						tsm_pkg::KIND_SUBSCRIBE: begin
							cmd.sub_byte = 1'b1;
							cmd.sub_last = last;
							if (last) begin
								state_d = tsm_pkg::ST_ACK_WAIT;
							end
						end
						tsm_pkg::KIND_PUBLISH: begin
							cmd.pub_read = 1'b1;
							state_d      = tsm_pkg::ST_PUB_CMP;
						end
						default: ;
					endcase
				end
			end
			tsm_pkg::ST_ACK_WAIT: begin
				if (status.out_free) begin
					cmd.load_ack = 1'b1;
					state_d      = tsm_pkg::ST_IDLE;
				end
			end
			tsm_pkg::ST_PUB_CMP: begin
				cmd.pub_cmp = 1'b1;
				state_d     = last_q ? tsm_pkg::ST_PUB_EVAL : tsm_pkg::ST_IDLE;
			end
			tsm_pkg::ST_PUB_EVAL: begin
				cmd.pub_eval = 1'b1;
				state_d      = tsm_pkg::ST_PUB_OUT;
			end
			tsm_pkg::ST_PUB_OUT: begin
				if (status.out_free) begin
					cmd.load_pub = 1'b1;
					state_d      = tsm_pkg::ST_IDLE;
				end
			end
			default: state_d = tsm_pkg::ST_IDLE;
		endcase
	end

endmodule

// ===== design/tsm_dpath.sv =====
// Datapath: slot table, pattern memories, match flags and result register.
module tsm_dpath #(
	parameter int SLOTS       = 16,
	parameter int TOPIC_BYTES = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  tsm_pkg::cmd_t                  cmd,
	output tsm_pkg::status_t               status,
	input  logic [3:0]                     slot,
	input  logic [7:0]                     ch,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           result_kind,
	output logic [tsm_pkg::MASK_W-1:0]     match_mask,
	output logic [tsm_pkg::COUNT_W-1:0]    match_count
);

	localparam int PW = $clog2(TOPIC_BYTES);
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam logic [PW-1:0] LAST_POS = PW'(TOPIC_BYTES - 1);

	// one pattern memory per slot, all read at the publish position
	logic [7:0]    mem_q [SLOTS][TOPIC_BYTES];
	logic [7:0]    rdata_q [SLOTS];
	logic [7:0]    ch_q;

	logic [SLOTS-1:0] active_q;
	logic [SLOTS-1:0] wild_q;
	logic [PW-1:0]    len_q [SLOTS];
	logic [SLOTS-1:0] equal_q;
	logic [SLOTS-1:0] hit_q;
	logic [PW-1:0]    sub_pos_q;
	logic [PW-1:0]    pub_pos_q;

	logic             out_valid_q;
	logic             result_kind_q;
	logic [tsm_pkg::MASK_W-1:0]  mask_q;
	logic [tsm_pkg::COUNT_W-1:0] count_q;

	logic          slot_ok;
	logic [SW-1:0] slot_idx;
	logic          sub_keep;
	logic          pub_keep;
	logic [SLOTS-1:0] is_wild;
	logic [PW-1:0]    cmp_len [SLOTS];
	logic [SLOTS-1:0] hit_d;
	logic [CW-1:0]    cnt;
	logic [tsm_pkg::COUNT_W-1:0] cnt_sat;
	logic [tsm_pkg::MASK_W-1:0]  mask_d;

	assign slot_ok  = 32'(slot) < SLOTS;
	assign slot_idx = SW'(slot);
	assign sub_keep = sub_pos_q != LAST_POS;
	assign pub_keep = pub_pos_q != LAST_POS;

	always_comb begin
		for (int s = 0; s < SLOTS; s++) begin
			is_wild[s] = wild_q[s] && (len_q[s] != '0);
			cmp_len[s] = is_wild[s] ? len_q[s] - PW'(1) : len_q[s];
			hit_d[s]   = active_q[s] && (len_q[s] != '0) && equal_q[s] &&
				(is_wild[s] ? (pub_pos_q >= cmp_len[s]) : (pub_pos_q == cmp_len[s]));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sub_byte && sub_keep && slot_ok) begin
			mem_q[slot_idx][sub_pos_q] <= ch;
		end
		if (cmd.pub_read) begin
			ch_q <= ch;
			for (int s = 0; s < SLOTS; s++) begin
				rdata_q[s] <= mem_q[s][pub_pos_q];
			end
		end
		if (cmd.pub_eval) begin
			hit_q <= hit_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= '0;
			wild_q    <= '0;
			equal_q   <= '1;
			sub_pos_q <= '0;
			pub_pos_q <= '0;
			for (int s = 0; s < SLOTS; s++) begin
				len_q[s] <= '0;
			end
		end else begin
			if (cmd.connect && slot_ok) begin
				active_q[slot_idx] <= 1'b1;
			end
			if (cmd.disconnect && slot_ok) begin
				active_q[slot_idx] <= 1'b0;
				len_q[slot_idx]    <= '0;
				wild_q[slot_idx]   <= 1'b0;
			end
			if (cmd.sub_byte) begin
				if (sub_keep) begin
					if (slot_ok) begin
						len_q[slot_idx]  <= sub_pos_q + PW'(1);
						wild_q[slot_idx] <= ch == tsm_pkg::WILDCARD_BYTE;
					end
					sub_pos_q <= sub_pos_q + PW'(1);
				end
				if (cmd.sub_last) begin
					sub_pos_q <= '0;
				end
			end
			if (cmd.pub_cmp && pub_keep) begin
				for (int s = 0; s < SLOTS; s++) begin
					if (pub_pos_q < cmp_len[s] && rdata_q[s] != ch_q) begin
						equal_q[s] <= 1'b0;
					end
				end
				pub_pos_q <= pub_pos_q + PW'(1);
			end
			// rearm for the next topic
			if (cmd.pub_eval) begin
				equal_q   <= '1;
				pub_pos_q <= '0;
			end
		end
	end

	always_comb begin
		cnt = '0;
		for (int s = 0; s < SLOTS; s++) begin
			cnt = cnt + CW'(hit_q[s]);
		end
		cnt_sat = (32'(cnt) > tsm_pkg::COUNT_MAX) ? tsm_pkg::COUNT_W'(tsm_pkg::COUNT_MAX)
		                                         : tsm_pkg::COUNT_W'(cnt);
	end

	for (genvar i = 0; i < tsm_pkg::MASK_W; i++) begin : g_mask
		if (i < SLOTS) begin : g_on
			assign mask_d[i] = hit_q[i];
		end else begin : g_off
			assign mask_d[i] = 1'b0;
		end
	end

	assign status.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_ack || cmd.load_pub) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_ack) begin
			result_kind_q <= tsm_pkg::RES_ACK;
			mask_q        <= '0;
			count_q       <= '0;
		end else if (cmd.load_pub) begin
			result_kind_q <= tsm_pkg::RES_PUB;
			mask_q        <= mask_d;
			count_q       <= cnt_sat;
		end
	end

	assign out_valid   = out_valid_q;
	assign result_kind = result_kind_q;
	assign match_mask  = mask_q;
	assign match_count = count_q;

endmodule

// ===== design/topic_subscription_matcher.sv =====
// Top level of the topic subscription matcher.
// Slot table of SLOTS subscribers, each with one stored topic pattern of up to TOPIC_BYTES-1
// bytes ('#' at the end matches any continuation). Connect, disconnect and non-final subscribe
// transactions are taken in IDLE. A final subscribe byte moves to ACK_WAIT, which returns an
// acknowledge once the output is free. A publish byte is a registered read of the per-slot
// pattern memories followed by the parallel compare; the final publish byte then passes
// PUB_EVAL, which evaluates every slot, and PUB_OUT, which counts hits and loads the result.
// The output register holds a result while the next transaction is taken; a new result waits
// for it to drain. Pattern storage needs no clearing after reset.
module topic_subscription_matcher #(
	parameter int SLOTS       = 16,
	parameter int TOPIC_BYTES = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  kind,
	input  logic [3:0]                  slot,
	input  logic [7:0]                  ch,
	input  logic                        last,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        result_kind,
	output logic [tsm_pkg::MASK_W-1:0]  match_mask,
	output logic [tsm_pkg::COUNT_W-1:0] match_count
);

	tsm_pkg::cmd_t    cmd;
	tsm_pkg::status_t status;

	tsm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.kind     (kind),
		.last     (last),
		.status   (status),
		.cmd      (cmd)
	);

	tsm_dpath #(
		.SLOTS       (SLOTS),
		.TOPIC_BYTES (TOPIC_BYTES)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.slot        (slot),
		.ch          (ch),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_kind (result_kind),
		.match_mask  (match_mask),
		.match_count (match_count)
	);

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the topic subscription matcher: random topic streams, idle mixes.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS       = 16;
	localparam int TOPIC_BYTES = 64;
	localparam int KEEP        = TOPIC_BYTES - 1;
	localparam int HOLD_CYCLES = 400;
	localparam int QUIET_LIMIT = 4000;

	typedef struct packed {
		logic                        rk;
		logic [tsm_pkg::MASK_W-1:0]  mask;
		logic [tsm_pkg::COUNT_W-1:0] hits;
	} match_result_t;

	// Shadow copy of the slot table; predicts acks and match sets in transaction order.
	class topic_match_tracker;
		bit            active [SLOTS];
		logic [7:0]    pat [SLOTS][TOPIC_BYTES];
		bit            filled [SLOTS][TOPIC_BYTES];
		logic [6:0]    plen [SLOTS];
		bit            still_eq [SLOTS];
		logic [6:0]    sub_pos;
		logic [6:0]    pub_pos;
		match_result_t due[$];
		int            errors;
		int            acks;
		int            match_sets;
		int            slot_hits;

		function new();
			for (int s = 0; s < SLOTS; s++) begin
				active[s]   = 1'b0;
				plen[s]     = '0;
				still_eq[s] = 1'b1;
				for (int p = 0; p < TOPIC_BYTES; p++) begin
					pat[s][p]    = 8'h00;
					filled[s][p] = 1'b0;
				end
			end
			sub_pos = '0;
			pub_pos = '0;
			errors  = 0;
		endfunction

		function bit wild(int s);
			return plen[s] != 0 && pat[s][plen[s] - 7'd1] == tsm_pkg::WILDCARD_BYTE;
		endfunction

		function logic [6:0] span(int s);
			return wild(s) ? plen[s] - 7'd1 : plen[s];
		endfunction

		function bit prefix_filled(int s, logic [6:0] n);
			for (int p = 0; p < n; p++)
				if (!filled[s][p])
					return 1'b0;
			return 1'b1;
		endfunction

		// Steer a subscribe byte away from slots whose earlier bytes were never written.
		function logic [3:0] legal_sub_slot(logic [3:0] want);
			if (sub_pos >= KEEP || prefix_filled(want, sub_pos))
				return want;
			for (int s = 0; s < SLOTS; s++)
				if (prefix_filled(s, sub_pos))
					return 4'(s);
			return want;
		endfunction

		function void take_item(tsm_pkg::kind_t k, logic [3:0] s, logic [7:0] c, bit l);
			match_result_t r;
			logic [6:0]    e;
			bit            hit;
			case (k)
				tsm_pkg::KIND_CONNECT: begin
					active[s] = 1'b1;
				end
				tsm_pkg::KIND_DISCONNECT: begin
					active[s] = 1'b0;
					plen[s]   = '0;
				end
				tsm_pkg::KIND_SUBSCRIBE: begin
					if (sub_pos < KEEP) begin
						pat[s][sub_pos]    = c;
						filled[s][sub_pos] = 1'b1;
						plen[s]            = sub_pos + 7'd1;
						sub_pos            = sub_pos + 7'd1;
					end
					if (l) begin
						sub_pos = '0;
						r.rk    = tsm_pkg::RES_ACK;
						r.mask  = '0;
						r.hits  = '0;
						due.push_back(r);
					end
				end
				default: begin
					if (pub_pos < KEEP) begin
						for (int i = 0; i < SLOTS; i++)
							if (pub_pos < span(i) && pat[i][pub_pos] != c)
								still_eq[i] = 1'b0;
						pub_pos = pub_pos + 7'd1;
					end
					if (l) begin
						r.rk   = tsm_pkg::RES_PUB;
						r.mask = '0;
						r.hits = '0;
						for (int i = 0; i < SLOTS; i++) begin
							e   = span(i);
							hit = active[i] && plen[i] != 0 && still_eq[i] &&
								(wild(i) ? pub_pos >= e : pub_pos == e);
							if (hit) begin
								r.mask[i] = 1'b1;
								if (r.hits < tsm_pkg::COUNT_MAX)
									r.hits = r.hits + 1'b1;
							end
							still_eq[i] = 1'b1;
						end
						pub_pos = '0;
						due.push_back(r);
					end
				end
			endcase
		endfunction

		task report_mismatch(string msg);
			$display("%0t mismatch: %s", $time, msg);
			errors++;
		endtask

		task check_result(logic rk, logic [tsm_pkg::MASK_W-1:0] m,
			logic [tsm_pkg::COUNT_W-1:0] c);
			match_result_t want;
			if (due.size() == 0) begin
				report_mismatch($sformatf("unexpected result kind=%0d mask=%h count=%0d",
					rk, m, c));
				return;
			end
			want = due.pop_front();
			if (rk !== want.rk)
				report_mismatch($sformatf("result_kind %0d, want %0d", rk, want.rk));
			if (m !== want.mask)
				report_mismatch($sformatf("match_mask %h, want %h", m, want.mask));
			if (c !== want.hits)
				report_mismatch($sformatf("match_count %0d, want %0d", c, want.hits));
			if (want.rk == tsm_pkg::RES_ACK)
				acks++;
			else begin
				match_sets++;
				slot_hits += want.hits;
			end
		endtask
	endclass

	logic                        clk         = 1'b0;
	logic                        arst_n      = 1'b0;
	logic                        in_valid    = 1'b0;
	logic                        in_stall;
	logic [1:0]                  kind        = '0;
	logic [3:0]                  slot        = '0;
	logic [7:0]                  ch          = '0;
	logic                        last        = 1'b0;
	logic                        out_valid;
	logic                        out_stall   = 1'b0;
	logic                        result_kind;
	logic [tsm_pkg::MASK_W-1:0]  match_mask;
	logic [tsm_pkg::COUNT_W-1:0] match_count;

	topic_match_tracker  sb = new();
	int                  items_sent     = 0;
	int                  send_idle_pct  = 0;
	int                  recv_stall_pct = 0;
	bit                  hold_req       = 1'b0;
	int                  hold_left      = 0;
	int                  quiet          = 0;

	topic_subscription_matcher #(
		.SLOTS      (SLOTS),
		.TOPIC_BYTES(TOPIC_BYTES)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.slot       (slot),
		.ch         (ch),
		.last       (last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.result_kind(result_kind),
		.match_mask (match_mask),
		.match_count(match_count)
	);

	always #2 clk = ~clk;

	// Receiver: random stall, or a long hold-off when requested.
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req  = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else
			out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Result checking and watchdog.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid === 1'b1 && out_stall == 1'b0)
				sb.check_result(result_kind, match_mask, match_count);
			if ((out_valid === 1'b1 && out_stall == 1'b0) ||
				(in_valid && in_stall === 1'b0))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles, %0d results outstanding",
					quiet, sb.due.size());
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// Drive one transaction; called and returns at a falling edge.
	task automatic send_item(tsm_pkg::kind_t k, logic [3:0] s, logic [7:0] c, bit l);
		logic [3:0] use_slot;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		use_slot = (k == tsm_pkg::KIND_SUBSCRIBE) ? sb.legal_sub_slot(s) : s;
		in_valid <= 1'b1;
		kind     <= k;
		slot     <= use_slot;
		ch       <= c;
		last     <= l;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		sb.take_item(k, use_slot, c, l);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(negedge clk);
		while (sb.due.size() != 0)
			@(negedge clk);
	endtask

	task automatic table_poke();
		send_item($urandom_range(1) ? tsm_pkg::KIND_CONNECT : tsm_pkg::KIND_DISCONNECT,
			4'($urandom), 8'($urandom), 1'($urandom));
	endtask

	task automatic sub_str(logic [3:0] s, string txt);
		for (int i = 0; i < txt.len(); i++)
			send_item(tsm_pkg::KIND_SUBSCRIBE, s, txt[i], i == txt.len() - 1);
	endtask

	task automatic pub_str(string txt);
		for (int i = 0; i < txt.len(); i++)
			send_item(tsm_pkg::KIND_PUBLISH, 4'($urandom), txt[i], i == txt.len() - 1);
	endtask

	function automatic logic [7:0] pick_char();
		int r;
		r = $urandom_range(99);
		if (r < 35)
			return "a";
		if (r < 55)
			return "b";
		if (r < 75)
			return "/";
		if (r < 80)
			return tsm_pkg::WILDCARD_BYTE;
		return 8'($urandom);
	endfunction

	// Mostly short topics, a few past the stored length.
	function automatic int topic_len();
		int r;
		r = $urandom_range(99);
		if (r < 94)
			return $urandom_range(1, 8);
		if (r < 97)
			return $urandom_range(9, 30);
		return $urandom_range(60, 70);
	endfunction

	// Stream one topic; occasionally touch the table between bytes.
	task automatic send_stream(tsm_pkg::kind_t k, logic [3:0] s, logic [7:0] t[$],
		int switch_at, logic [3:0] s2);
		logic [3:0] use_slot;
		for (int i = 0; i < t.size(); i++) begin
			if (i > 0 && $urandom_range(99) < 3)
				table_poke();
			if (k == tsm_pkg::KIND_PUBLISH)
				use_slot = 4'($urandom);
			else
				use_slot = (i >= switch_at) ? s2 : s;
			send_item(k, use_slot, t[i], i == t.size() - 1);
		end
	endtask

	task automatic random_subscribe();
		logic [7:0] t[$];
		int         n;
		int         sw;
		n = topic_len();
		repeat (n)
			t.push_back(pick_char());
		if ($urandom_range(99) < 8)
			t = '{tsm_pkg::WILDCARD_BYTE};
		else if ($urandom_range(99) < 40)
			t[t.size() - 1] = tsm_pkg::WILDCARD_BYTE;
		sw = t.size();
		if (t.size() > 1 && $urandom_range(99) < 6)
			sw = $urandom_range(1, t.size() - 1);
		send_stream(tsm_pkg::KIND_SUBSCRIBE, 4'($urandom), t, sw, 4'($urandom));
	endtask

	// Build a topic from a stored pattern most of the time so that matches happen.
	task automatic random_publish();
		logic [7:0] t[$];
		int         s;
		int         n;
		if ($urandom_range(99) < 65) begin
			s = $urandom_range(SLOTS - 1);
			if (sb.plen[s] != 0) begin
				n = sb.span(s);
				for (int i = 0; i < n; i++)
					t.push_back(sb.pat[s][i]);
				if (sb.wild(s))
					repeat ($urandom_range(4))
						t.push_back(pick_char());
				case ($urandom_range(9))
					0: if (t.size() > 0) begin
						n    = $urandom_range(t.size() - 1);
						t[n] = t[n] ^ (8'h01 << $urandom_range(7));
					end
					1: if (t.size() > 1)
						void'(t.pop_back());
					2: t.push_back(pick_char());
					default: ;
				endcase
			end
		end
		if (t.size() == 0) begin
			n = topic_len();
			repeat (n)
				t.push_back(pick_char());
		end
		send_stream(tsm_pkg::KIND_PUBLISH, 4'h0, t, t.size(), 4'h0);
	endtask

	task automatic random_action();
		int r;
		r = $urandom_range(99);
		if (r < 9)
			send_item(tsm_pkg::KIND_CONNECT, 4'($urandom), 8'($urandom), 1'($urandom));
		else if (r < 14)
			send_item(tsm_pkg::KIND_DISCONNECT, 4'($urandom), 8'($urandom), 1'($urandom));
		else if (r < 42)
			random_subscribe();
		else if (r < 86)
			random_publish();
		else
			send_item(tsm_pkg::kind_t'($urandom_range(3)), 4'($urandom), 8'($urandom),
				1'($urandom));
	endtask

	task automatic run_phase(int sidle, int rstall, int n, bit squeeze);
		int stop;
		int squeeze_at;
		send_idle_pct  = sidle;
		recv_stall_pct = rstall;
		stop       = items_sent + n;
		squeeze_at = items_sent + n / 3;
		while (items_sent < stop) begin
			if (squeeze && items_sent >= squeeze_at) begin
				hold_req = 1'b1;
				squeeze  = 1'b0;
			end
			random_action();
		end
		drain_results();
	endtask

	initial begin
		repeat (9)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_item(tsm_pkg::KIND_CONNECT, 4'd0, 8'h00, 1'b0);
		send_item(tsm_pkg::KIND_CONNECT, 4'd15, 8'hFF, 1'b1);
		// connect of a slot that is already active
		send_item(tsm_pkg::KIND_CONNECT, 4'd15, 8'h5A, 1'b0);
		sub_str(4'd0, "#");
		sub_str(4'd15, "a/#");
		pub_str("a/b");
		// single-byte topics at the byte extremes, NUL included
		send_item(tsm_pkg::KIND_PUBLISH, 4'd15, 8'h00, 1'b1);
		send_item(tsm_pkg::KIND_PUBLISH, 4'd0, 8'hFF, 1'b1);
		// subscribe to an inactive slot, then connect it
		sub_str(4'd5, "x");
		pub_str("x");
		send_item(tsm_pkg::KIND_CONNECT, 4'd5, 8'h00, 1'b0);
		pub_str("x");
		// drop a slot in the middle of a publish
		send_item(tsm_pkg::KIND_PUBLISH, 4'd0, "a", 1'b0);
		send_item(tsm_pkg::KIND_DISCONNECT, 4'd15, 8'h00, 1'b0);
		send_item(tsm_pkg::KIND_PUBLISH, 4'd0, "/", 1'b1);
		// switch slots inside one subscribe
		send_item(tsm_pkg::KIND_SUBSCRIBE, 4'd3, "q", 1'b0);
		send_item(tsm_pkg::KIND_SUBSCRIBE, 4'd15, "z", 1'b1);
		send_item(tsm_pkg::KIND_CONNECT, 4'd3, 8'h00, 1'b0);
		send_item(tsm_pkg::KIND_CONNECT, 4'd15, 8'h00, 1'b0);
		pub_str("az");
		send_item(tsm_pkg::KIND_DISCONNECT, 4'd0, 8'h00, 1'b0);
		drain_results();

		run_phase(0, 0, 440, 1'b1);
		run_phase(82, 0, 440, 1'b0);
		run_phase(0, 82, 440, 1'b0);
		run_phase(18, 18, 440, 1'b0);

		// let any stray result show up
		repeat (32)
			@(negedge clk);

		$display("covered %0d input transactions: %0d acks and %0d match sets, %0d slot hits",
			items_sent, sb.acks, sb.match_sets, sb.slot_hits);
		$display("idle mixes: none, sender, receiver, both; one long output hold-off");
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
